[sv/radix_digit_converter_defines.svh]
// Assertion macros for the radix digit converter.
`ifndef RADIX_DIGIT_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_CONVERTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("radix_digit_converter: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("radix_digit_converter: next-cycle check failed");

`endif

[sv/rdc_pkg.sv]
// Package: widths, microcode format and program, digit table.
`default_nettype none
package rdc_pkg;

  localparam int VALUE_BITS = 31;
  localparam int RADIX_W    = 5;
  localparam int DIGIT_W    = 4;
  localparam int CHAR_W     = 7;
  // Bits of quotient developed per divider cycle.
  localparam int CHUNK      = 8;
  localparam int NCHUNK     = (VALUE_BITS + CHUNK - 1) / CHUNK;
  localparam int PAD_BITS   = NCHUNK * CHUNK;
  localparam int CNT_W      = $clog2(NCHUNK + 1);
  // Digit stack: at most VALUE_BITS digits.
  localparam int SP_W       = $clog2(VALUE_BITS + 1);
  localparam int IDX_W      = $clog2(VALUE_BITS);

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  // Microcode step addresses.
  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;
  localparam upc_t U_IDLE = 3'd0;
  localparam upc_t U_DIV  = 3'd1;
  localparam upc_t U_PUSH = 3'd2;
  localparam upc_t U_WAIT = 3'd3;
  localparam upc_t U_EMIT = 3'd4;
  localparam upc_t U_BACK = 3'd5;

  // Jump conditions.
  typedef enum logic [2:0] {
    C_NEVER      = 3'd0,
    C_ALWAYS     = 3'd1,
    C_NO_INPUT   = 3'd2,
    C_CHUNK_LEFT = 3'd3,
    C_QUOT_NZ    = 3'd4,
    C_OUT_BUSY   = 3'd5,
    C_MORE       = 3'd6
  } cond_t;

  typedef struct packed {
    logic  take_in;   // input channel ready
    logic  div_step;  // run one divider chunk
    logic  push;      // push remainder, start next division
    logic  emit;      // pop one digit into the output register
    cond_t cond;      // jump when true, else fall through
    upc_t  target;
  } ucw_t;

  // Divider control group.
  typedef struct packed {
    logic load;
    logic step;
    logic next_div;
  } div_ctl_t;

  // Control store.
  function automatic ucw_t ucode_word(input upc_t upc);
    ucw_t w;
    w = '{take_in: 1'b0, div_step: 1'b0, push: 1'b0, emit: 1'b0,
          cond: C_ALWAYS, target: U_IDLE};
    case (upc)
      U_IDLE: begin
        w.take_in = 1'b1;
        w.cond    = C_NO_INPUT;
        w.target  = U_IDLE;
      end
      U_DIV: begin
        w.div_step = 1'b1;
        w.cond     = C_CHUNK_LEFT;
        w.target   = U_DIV;
      end
      U_PUSH: begin
        w.push   = 1'b1;
        w.cond   = C_QUOT_NZ;
        w.target = U_DIV;
      end
      U_WAIT: begin
        w.cond   = C_OUT_BUSY;
        w.target = U_WAIT;
      end
      U_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = C_MORE;
        w.target = U_WAIT;
      end
      U_BACK: begin
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = U_IDLE;
      end
    endcase
    return w;
  endfunction

  localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
    7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
  };

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    return DIGIT_CHARS[d];
  endfunction

endpackage
`default_nettype wire

[sv/rdc_div.sv]
// Chunked restoring divider: value / radix, CHUNK quotient bits per cycle.
`default_nettype none
module rdc_div import rdc_pkg::*; (
  input  wire logic                  clk,
  input  wire div_ctl_t              ctl,
  input  wire logic [VALUE_BITS-1:0] load_value,
  input  wire logic [RADIX_W-1:0]    load_radix,
  output logic      [PAD_BITS-1:0]   quot,
  output logic      [DIGIT_W-1:0]    rem
);

  logic [PAD_BITS-1:0] q_r, q_nxt;
  logic [DIGIT_W-1:0]  rem_r, rem_nxt;
  logic [RADIX_W-1:0]  radix_r, radix_clamped;

  always_comb begin
    if (load_radix < RADIX_MIN) begin
      radix_clamped = RADIX_MIN;
    end else if (load_radix > RADIX_MAX) begin
      radix_clamped = RADIX_MAX;
    end else begin
      radix_clamped = load_radix;
    end
  end

  // Dividend shifts out at the top, quotient bits shift in at the bottom.
  always_comb begin
    logic [PAD_BITS-1:0] q;
    logic [DIGIT_W-1:0]  r;
    logic [RADIX_W-1:0]  t;
    q = q_r;
    r = rem_r;
    t = '0;
    for (int i = 0; i < CHUNK; i++) begin
      t = {r, q[PAD_BITS-1]};
      q = {q[PAD_BITS-2:0], 1'b0};
      if (t >= radix_r) begin
        t    = t - radix_r;
        q[0] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    q_nxt   = q;
    rem_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q_r     <= PAD_BITS'(load_value);
      rem_r   <= '0;
      radix_r <= radix_clamped;
    end else if (ctl.step) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end else if (ctl.next_div) begin
      rem_r <= '0;
    end
  end

  assign quot = q_r;
  assign rem  = rem_r;

endmodule
`default_nettype wire

[sv/radix_digit_converter.sv]
// Top level: microcoded integer to ASCII digit converter.
//
//   channel  dir  handshake              payload
//   in_      in   in_valid / in_ready    in_value[30:0], in_radix[4:0]
//   out_     out  out_valid / out_ready  out_digit_char[6:0], out_last
//
// One division repeats the divider step over all NCHUNK (4) chunks of the
// dividend, then one push step follows. An item is divided digit by digit until
// the quotient is zero; each digit then passes a wait step and an emit step, and
// a return step leads back to idle. The divider loop develops 8 quotient bits per cycle.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_valid. A stalled output holds the sequencer in its wait step; a new
// item is taken while the final digit still sits in the output register.
`default_nettype none
`include "radix_digit_converter_defines.svh"
module radix_digit_converter import rdc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [VALUE_BITS-1:0] in_value,
  input  wire logic [RADIX_W-1:0]    in_radix,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [CHAR_W-1:0]     out_digit_char,
  output logic                       out_last
);

  // Sequencer
  upc_t  upc_r, upc_nxt;
  ucw_t  uw;
  logic  jump;
  logic  accept;

  // Chunk counter within one division
  logic [CNT_W-1:0] cnt_r;

  // Digit stack, least significant digit pushed first
  logic [DIGIT_W-1:0] stk_r [VALUE_BITS];
  logic [SP_W-1:0]    sp_r;
  logic [IDX_W-1:0]   top_idx;

  // Output register
  logic              out_valid_r;
  logic [CHAR_W-1:0] out_char_r;
  logic              out_last_r;

  // Divider
  div_ctl_t            dctl;
  logic [PAD_BITS-1:0] quot;
  logic [DIGIT_W-1:0]  rem;

  assign uw       = ucode_word(upc_r);
  assign in_ready = uw.take_in;
  assign accept   = uw.take_in & in_valid;

  always_comb begin
    case (uw.cond)
      C_NEVER:      jump = 1'b0;
      C_ALWAYS:     jump = 1'b1;
      C_NO_INPUT:   jump = !in_valid;
      C_CHUNK_LEFT: jump = (cnt_r != CNT_W'(NCHUNK - 1));
      C_QUOT_NZ:    jump = (quot != '0);
      C_OUT_BUSY:   jump = out_valid_r & !out_ready;
      C_MORE:       jump = (sp_r != SP_W'(1));
      default:      jump = 1'b0;
    endcase
  end

  assign upc_nxt = jump ? uw.target : upc_r + upc_t'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= U_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

  assign dctl = '{load: accept, step: uw.div_step, next_div: uw.push};

  rdc_div u_div (
    .clk        (clk),
    .ctl        (dctl),
    .load_value (in_value),
    .load_radix (in_radix),
    .quot       (quot),
    .rem        (rem)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept || uw.push) begin
      cnt_r <= '0;
    end else if (uw.div_step) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Stack pointer counts stored digits; top entry sits at sp - 1.
  assign top_idx = IDX_W'(sp_r - SP_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r <= '0;
    end else if (accept) begin
      sp_r <= '0;
    end else if (uw.push) begin
      sp_r <= sp_r + SP_W'(1);
    end else if (uw.emit) begin
      sp_r <= sp_r - SP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (uw.push) begin
      stk_r[sp_r[IDX_W-1:0]] <= rem;
    end
  end

  // The wait step guarantees the output register is free at emit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (uw.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (uw.emit) begin
      out_char_r <= digit_char(stk_r[top_idx]);
      out_last_r <= (sp_r == SP_W'(1));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = out_char_r;
  assign out_last       = out_last_r;

  // A fresh item always starts with an empty stack and a cleared counter.
  `RDC_ASSERT_NEXT(a_new_item_empty, accept, (sp_r == '0) && (cnt_r == '0))
  // Never pop an empty stack, never overwrite a waiting digit.
  `RDC_ASSERT_NOW(a_emit_safe, uw.emit, (sp_r != '0) && !out_valid_r)
  // Push never runs past the deepest digit count.
  `RDC_ASSERT_NOW(a_push_bound, uw.push, sp_r < SP_W'(VALUE_BITS))

endmodule
`default_nettype wire
